### hdl/lstd_pkg.sv
`timescale 1ns / 1ps

package lstd_pkg;

    localparam int LINE_LEN    = 128;
    localparam int PIX_W       = $clog2(LINE_LEN);
    localparam int SAMPLE_W    = 14;
    localparam int SMOOTH_W    = 15;
    localparam int COUNT_W     = 8;
    localparam int RADIUS      = 2;
    localparam int WIN_LEN     = 2 * RADIUS + 1;
    localparam int SUM_W       = SAMPLE_W + 3;
    localparam int THR_W       = SMOOTH_W + 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_PUSH    = RADIUS + 1;
    localparam int PUSH_W      = $clog2(MAX_PUSH + 1);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_W       = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int RIGHT_RESET = LINE_LEN - 1;
    localparam int OFF_MIN_RESET = 30;

    typedef logic [PIX_W-1:0]    pix_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SMOOTH_W-1:0] smooth_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE   = 2'd0,
        CFG_DARK    = 2'd1,
        CFG_OFF_MIN = 2'd2
    } cfg_idx_t;

    // Input stage contents: the pixel's index, its window (newest first) and
    // the running line extremes including this pixel.
    typedef struct packed {
        logic                       valid;
        pix_t                       n;
        logic [WIN_LEN-1:0][SAMPLE_W-1:0] win;
        sample_t                    run_min;
        sample_t                    run_max;
    } win_stage_t;

    typedef struct packed {
        pix_t    pixel_index;
        smooth_t smoothed;
        logic    bright;
        logic    line_end;
        pix_t    left_edge;
        pix_t    right_edge;
        count_t  bright_count;
        logic    off_track;
        sample_t line_min;
        sample_t line_max;
    } result_t;

    // Results of one pixel, in delivery order; only the first count are used.
    typedef struct packed {
        logic [PUSH_W-1:0]             count;
        result_t [MAX_PUSH-1:0]        item;
    } push_t;

endpackage

### hdl/line_scan_track_detect_unit.sv
`timescale 1ns / 1ps

// Path: an accepted pixel is held in the input stage register, then its results (if
//   any) enter the output queue, whose head register drives m_tdata; a line's last
//   pixel puts three results there. Throughput: one pixel and one result per cycle
//   while m_tready stays high; the four-entry queue absorbs the line-end burst.
// Reset: aresetn, synchronous, active low; clears the window, pixel counter,
//   line statistics, edge history (right edge 127) and registers (minimum 30).
module line_scan_track_detect_unit import lstd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input pixel stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [13:0] sample
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [6:0] pixel_index, [21:7] smoothed,
                                              // [22] bright, [29:23] left_edge,
                                              // [36:30] right_edge, [44:37] bright_count,
                                              // [45] off_track, [59:46] line_min,
                                              // [73:60] line_max, rest zero
    output logic                   m_tlast,   // line_end
    // register writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    sample_t           white_reg, dark_reg;
    count_t            off_min_reg;
    win_stage_t        stage;
    logic              advance;
    push_t             push;
    logic [QCNT_W-1:0] q_count;
    result_t           head;

    // Register file: write-only, taken on any cycle with the enable high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            white_reg   <= '0;
            dark_reg    <= '0;
            off_min_reg <= COUNT_W'(OFF_MIN_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WHITE:   white_reg   <= cfg_wdata[SAMPLE_W-1:0];
                CFG_DARK:    dark_reg    <= cfg_wdata[SAMPLE_W-1:0];
                CFG_OFF_MIN: off_min_reg <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input stage: hold one pixel with its five-sample window.
    lstd_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_W-1:0]),
        .advance   (advance),
        .stage     (stage)
    );

    // Smooth, binarize and track the line; advance only when the queue has
    // room for every result this pixel produces.
    lstd_classify u_classify (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage         (stage),
        .white_level   (white_reg),
        .dark_level    (dark_reg),
        .off_track_min (off_min_reg),
        .q_count       (q_count),
        .advance       (advance),
        .push          (push)
    );

    // Output queue: its head register drives the result beat.
    lstd_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .q_count   (q_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tlast = head.line_end;
    assign m_tdata = {6'd0,
                      head.line_max,
                      head.line_min,
                      head.off_track,
                      head.bright_count,
                      head.right_edge,
                      head.left_edge,
                      head.bright,
                      head.smoothed,
                      head.pixel_index};

endmodule

### hdl/lstd_window.sv
`timescale 1ns / 1ps

module lstd_window import lstd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  sample_t    in_sample,
    input  logic       advance,
    output win_stage_t stage
);

    win_stage_t stage_reg, stage_next;
    pix_t       cnt_reg, cnt_next;
    logic       accept;

    assign in_ready = !stage_reg.valid || advance;
    assign accept   = in_valid && in_ready;
    assign stage    = stage_reg;

    always_comb begin
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        if (advance) begin
            stage_next.valid = 1'b0;
        end
        if (accept) begin
            stage_next.valid = 1'b1;
            stage_next.n     = cnt_reg;
            for (int k = WIN_LEN - 1; k > 0; k--) begin
                stage_next.win[k] = stage_reg.win[k-1];
            end
            stage_next.win[0] = in_sample;
            // restart extremes on the first pixel of a line
            if (cnt_reg == '0) begin
                stage_next.run_min = in_sample;
                stage_next.run_max = in_sample;
            end else begin
                if (in_sample < stage_reg.run_min) stage_next.run_min = in_sample;
                if (in_sample > stage_reg.run_max) stage_next.run_max = in_sample;
            end
            cnt_next = (cnt_reg == PIX_W'(LINE_LEN - 1)) ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hdl/lstd_classify.sv
`timescale 1ns / 1ps

module lstd_classify import lstd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  win_stage_t        stage,
    input  sample_t           white_level,
    input  sample_t           dark_level,
    input  count_t            off_track_min,
    input  logic [QCNT_W-1:0] q_count,
    output logic              advance,
    output push_t             push
);

    typedef struct packed {
        count_t tally;
        logic   left_found;
        logic   right_found;
        pix_t   left_seen;
        pix_t   right_seen;
        pix_t   left_limit;
        pix_t   right_limit;
    } stats_t;

    function automatic stats_t add_pixel(stats_t s, pix_t pix, logic b);
        stats_t r;
        r = s;
        if (b) begin
            r.tally = s.tally + 1'b1;
            if (!s.left_found) begin
                r.left_found = 1'b1;
                r.left_seen  = pix;
            end
            if (pix != '0) begin
                r.right_found = 1'b1;
                r.right_seen  = pix;
            end
        end
        return r;
    endfunction

    stats_t stats_reg, stats_next;
    stats_t st_a, st_b, st_c, st_fin;

    logic signed [SMOOTH_W-1:0] diff;
    logic signed [SMOOTH_W-1:0] half;
    logic signed [THR_W-1:0]    thresh;
    logic [SUM_W-1:0]           sum;
    logic [SMOOTH_W:0]          avg;
    smooth_t                    val [MAX_PUSH];
    pix_t                       pix [MAX_PUSH];
    logic                       bright [MAX_PUSH];
    pix_t                       p0;
    logic                       has_norm, line_done, raw_pix, fits;
    logic [PUSH_W-1:0]          need;
    logic [QCNT_W:0]            room;

    // threshold: 2*trunc((white-dark)/2) + 3*dark, half rounded toward zero
    assign diff   = SMOOTH_W'(white_level) - SMOOTH_W'(dark_level);
    assign half   = (diff + $signed(SMOOTH_W'(diff[SMOOTH_W-1]))) >>> 1;
    assign thresh = (THR_W'(half) <<< 1) + THR_W'(dark_level) + (THR_W'(dark_level) << 1);

    always_comb begin
        sum = '0;
        for (int k = 0; k < WIN_LEN; k++) begin
            sum = sum + SUM_W'(stage.win[k]);
        end
    end

    assign p0        = stage.n - PIX_W'(RADIUS);
    assign has_norm  = stage.n >= PIX_W'(RADIUS);
    assign line_done = stage.n == PIX_W'(LINE_LEN - 1);
    assign raw_pix   = (p0 < PIX_W'(RADIUS)) || (p0 > PIX_W'(LINE_LEN - 1 - RADIUS));
    assign avg       = (SMOOTH_W + 1)'(sum >> 2) + 1'b1;

    always_comb begin
        if (raw_pix) begin
            val[0] = SMOOTH_W'(stage.win[RADIUS]);
        end else if (avg[SMOOTH_W]) begin
            val[0] = '1;
        end else begin
            val[0] = avg[SMOOTH_W-1:0];
        end
        pix[0] = p0;
        // flush the tail pixels raw at line end
        for (int k = 1; k < MAX_PUSH; k++) begin
            val[k] = SMOOTH_W'(stage.win[RADIUS - k]);
            pix[k] = stage.n - PIX_W'(RADIUS - k);
        end
        for (int k = 0; k < MAX_PUSH; k++) begin
            bright[k] = $signed({2'b00, val[k], 1'b0}) > thresh;
        end
    end

    assign need    = has_norm ? (line_done ? PUSH_W'(MAX_PUSH) : PUSH_W'(1)) : '0;
    assign room    = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(need);
    assign fits    = room <= (QCNT_W + 1)'(QUEUE_DEPTH);
    assign advance = stage.valid && fits;

    always_comb begin
        st_a = has_norm ? add_pixel(stats_reg, pix[0], bright[0]) : stats_reg;
        st_b = line_done ? add_pixel(st_a, pix[1], bright[1]) : st_a;
        st_c = line_done ? add_pixel(st_b, pix[2], bright[2]) : st_b;
        st_fin = st_c;
        if (st_c.left_found)  st_fin.left_limit  = st_c.left_seen;
        if (st_c.right_found) st_fin.right_limit = st_c.right_seen;
    end

    always_comb begin
        push = '0;
        push.count = advance ? need : '0;
        for (int k = 0; k < MAX_PUSH; k++) begin
            push.item[k].pixel_index = pix[k];
            push.item[k].smoothed    = val[k];
            push.item[k].bright      = bright[k];
        end
        // summary rides on the final result only
        push.item[MAX_PUSH-1].line_end     = 1'b1;
        push.item[MAX_PUSH-1].left_edge    = st_fin.left_limit;
        push.item[MAX_PUSH-1].right_edge   = st_fin.right_limit;
        push.item[MAX_PUSH-1].bright_count = st_fin.tally;
        push.item[MAX_PUSH-1].off_track    = st_fin.tally < off_track_min;
        push.item[MAX_PUSH-1].line_min     = stage.run_min;
        push.item[MAX_PUSH-1].line_max     = stage.run_max;
    end

    always_comb begin
        stats_next = stats_reg;
        if (advance) begin
            if (line_done) begin
                stats_next             = '0;
                stats_next.left_limit  = st_fin.left_limit;
                stats_next.right_limit = st_fin.right_limit;
            end else begin
                stats_next = st_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= {COUNT_W'(0), 1'b0, 1'b0, PIX_W'(0), PIX_W'(0), PIX_W'(0),
                          PIX_W'(RIGHT_RESET)};
        end else begin
            stats_reg <= stats_next;
        end
    end

endmodule

### hdl/lstd_out_queue.sv
`timescale 1ns / 1ps

module lstd_out_queue import lstd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  push_t             push,
    output logic [QCNT_W-1:0] q_count,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_item
);

    result_t           q_reg  [QUEUE_DEPTH];
    result_t           q_next [QUEUE_DEPTH];
    result_t           shifted [QUEUE_DEPTH];
    logic [QCNT_W-1:0] count_reg, count_next, base, off;
    logic              pop;

    assign out_valid = count_reg != '0;
    assign out_item  = q_reg[0];
    assign q_count   = count_reg;
    assign pop       = out_valid && out_ready;
    assign base      = count_reg - QCNT_W'(pop);
    assign count_next = base + QCNT_W'(push.count);

    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            shifted[j] = q_reg[j+1];
        end
        shifted[QUEUE_DEPTH-1] = q_reg[QUEUE_DEPTH-1];
    end

    // drop the head on pop, append new results behind what remains
    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            off = QCNT_W'(j) - base;
            if (QCNT_W'(j) >= base && off < QCNT_W'(push.count)) begin
                q_next[j] = push.item[off[PUSH_W-1:0]];
            end else if (pop) begin
                q_next[j] = shifted[j];
            end else begin
                q_next[j] = q_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            q_reg[j] <= q_next[j];
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the line-scan track detector. Pixels stream in on
// the s_ side, smoothed and binarized pixels come back on the m_ side, and the
// last result of each line carries the line summary (edges, bright count,
// off-track flag, raw extremes). A scoreboard object tracks the same window,
// line statistics and edge history as the block and checks every result beat
// field by field, in order.
module testbench;
    import lstd_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES     = 60;    // long receiver stall to fill the queue
    localparam int DRAIN_CYCLES    = 8;     // pixels 0 and 1 of a line return nothing
    localparam int TAIL_PIXELS     = 14;    // opening pixels of the last, partial line

    // Opening pixels: field extremes, a window full of maximum values (largest
    // smoothed value), a window of zeros (smoothed value is just the +1), and
    // alternating bit patterns.
    localparam sample_t OPENING_PIXELS [24] = '{
        14'd0,     14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF,
        14'h3FFF,  14'd0,    14'd0,    14'd0,    14'd0,    14'd0,
        14'd1,     14'd2,    14'h2AAA, 14'h1555, 14'h3FFE, 14'd1,
        14'h2000,  14'h1FFF, 14'h3FFF, 14'd0,    14'h3FFF, 14'd0
    };

    // Tracks the detector state and holds the results each pixel is due to
    // produce, oldest first.
    class line_track_board;
        logic [SAMPLE_W-1:0] white;
        logic [SAMPLE_W-1:0] dark;
        logic [COUNT_W-1:0]  track_min;

        sample_t history [2*RADIUS];   // newest first
        int      pixel_pos;
        sample_t lo;
        sample_t hi;
        int      tally;
        pix_t    left_keep;
        pix_t    right_keep;
        bit      left_hit;
        bit      right_hit;
        pix_t    left_now;
        pix_t    right_now;

        result_t awaited [$];
        int      errors;
        int      checked;
        int      bright_seen;
        int      lines_seen;
        int      pixels_seen;

        function new();
            white      = '0;
            dark       = '0;
            track_min  = COUNT_W'(OFF_MIN_RESET);
            foreach (history[k]) history[k] = '0;
            pixel_pos  = 0;
            lo         = '0;
            hi         = '0;
            tally      = 0;
            left_keep  = '0;
            right_keep = pix_t'(RIGHT_RESET);
            left_hit   = 1'b0;
            right_hit  = 1'b0;
            left_now   = '0;
            right_now  = '0;
            errors     = 0;
            checked    = 0;
            bright_seen = 0;
            lines_seen = 0;
            pixels_seen = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_WHITE:   white = value[SAMPLE_W-1:0];
                CFG_DARK:    dark = value[SAMPLE_W-1:0];
                CFG_OFF_MIN: track_min = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact threshold test; the half-span truncates toward zero, also when
        // dark sits above white.
        function bit is_bright(int v);
            int half;
            half = (int'(white) - int'(dark)) / 2;
            return 2 * v > 2 * half + 3 * int'(dark);
        endfunction

        function void emit(int p, int v, bit last);
            result_t r;
            bit lit;
            lit = is_bright(v);
            if (lit) begin
                tally++;
                if (!left_hit) begin
                    left_hit = 1'b1;
                    left_now = pix_t'(p);
                end
                // pixel 0 may open the line's left edge but never its right edge
                if (p >= 1) begin
                    right_hit = 1'b1;
                    right_now = pix_t'(p);
                end
            end
            r = '0;
            r.pixel_index = pix_t'(p);
            r.smoothed    = smooth_t'(v);
            r.bright      = lit;
            r.line_end    = last;
            if (last) begin
                // edges without a bright pixel keep the previous line's value
                if (left_hit) left_keep = left_now;
                if (right_hit) right_keep = right_now;
                r.left_edge    = left_keep;
                r.right_edge   = right_keep;
                r.bright_count = count_t'(tally);
                r.off_track    = (tally < track_min);
                r.line_min     = lo;
                r.line_max     = hi;
                tally     = 0;
                left_hit  = 1'b0;
                right_hit = 1'b0;
                left_now  = '0;
                right_now = '0;
            end
            awaited.push_back(r);
        endfunction

        function void take_pixel(sample_t s);
            sample_t win [2*RADIUS+1];
            int      total;
            int      p;
            int      v;
            bit      line_done;
            win[0] = s;
            for (int k = 0; k < 2*RADIUS; k++) win[k+1] = history[k];
            line_done = (pixel_pos == LINE_LEN - 1);

            if (pixel_pos == 0) begin
                lo = s;
                hi = s;
            end else begin
                if (s < lo) lo = s;
                if (s > hi) hi = s;
            end

            // the pixel RADIUS places back is now complete
            if (pixel_pos >= RADIUS) begin
                p = pixel_pos - RADIUS;
                if (p < RADIUS || p > LINE_LEN - 1 - RADIUS) begin
                    v = win[RADIUS];
                end else begin
                    total = 0;
                    foreach (win[k]) total += win[k];
                    v = total / (2*RADIUS) + 1;
                    if (v > 32767) v = 32767;
                end
                emit(p, v, 1'b0);
            end

            // last pixel of the line flushes the raw end pixels
            if (line_done) begin
                for (int k = RADIUS - 1; k >= 0; k--) emit(pixel_pos - k, win[k], k == 0);
            end

            for (int k = 2*RADIUS - 1; k > 0; k--) history[k] = history[k-1];
            history[0] = s;
            pixel_pos = line_done ? 0 : pixel_pos + 1;
            pixels_seen++;
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d, logic last);
            result_t want;
            if (awaited.size() == 0) begin
                $error("result for pixel %0d arrived with none expected", d[6:0]);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("pixel_index",  want.pixel_index,  d[6:0]);
            compare("smoothed",     want.smoothed,     d[21:7]);
            compare("bright",       want.bright,       d[22]);
            compare("line_end",     want.line_end,     last);
            compare("left_edge",    want.left_edge,    d[29:23]);
            compare("right_edge",   want.right_edge,   d[36:30]);
            compare("bright_count", want.bright_count, d[44:37]);
            compare("off_track",    want.off_track,    d[45]);
            compare("line_min",     want.line_min,     d[59:46]);
            compare("line_max",     want.line_max,     d[73:60]);
            checked++;
            if (want.bright) bright_seen++;
            if (want.line_end) lines_seen++;
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // [13:0] sample
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [6:0] pixel_index, [21:7] smoothed,
                                              // [22] bright, [29:23] left_edge,
                                              // [36:30] right_edge, [44:37] bright_count,
                                              // [45] off_track, [59:46] line_min,
                                              // [73:60] line_max
    logic                   m_tlast;          // line_end
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_WHITE;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    line_track_board board;
    bit src_idle = 1'b1;     // sender inserts gaps
    bit snk_idle = 1'b1;     // receiver inserts stalls
    bit hold_done = 1'b0;
    int quiet_cycles = 0;
    int writes_done = 0;

    line_scan_track_detect_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function int gap_len(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Quiet lines: full-scale pixel 0, everything else well below threshold.
    // Otherwise: zeros, full scale, values near the thresholds, uniform.
    function sample_t pick_sample(bit quiet, bit line_head);
        int r;
        if (quiet) return line_head ? '1 : sample_t'($urandom_range(0, 4000));
        r = $urandom_range(0, 7);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return sample_t'($urandom_range(8000, 10000));
            default: return sample_t'($urandom_range(0, 16383));
        endcase
    endfunction

    // Sample both sides at the rising edge; note the pixel before checking
    // so a same-edge result would still find its expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.take_pixel(s_tdata[SAMPLE_W-1:0]);
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
        end
    end

    // End the run if no beat moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Timeout: no beat moved for %0d cycles", WATCHDOG_CYCLES);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off once 30 results are in,
    // while the sender keeps offering so the output queue fills and stalls it.
    initial begin
        int low;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (!hold_done && board.checked >= 30) begin
                low = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                low = gap_len(snk_idle);
            end
            if (low > 0) begin
                m_tready <= 1'b0;
                repeat (low) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
        end
    end

    // Wait until every expected result is out, then let a line's silent
    // opening pixels clear the block as well.
    task settle();
        while (board.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write all three registers on consecutive cycles, block idle.
    task write_settings(input logic [CFG_W-1:0] white, input logic [CFG_W-1:0] dark,
                        input logic [CFG_W-1:0] minimum);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WHITE;
        cfg_wdata <= white;
        board.set_register(CFG_WHITE, white);
        @(negedge aclk);
        cfg_index <= CFG_DARK;
        cfg_wdata <= dark;
        board.set_register(CFG_DARK, dark);
        @(negedge aclk);
        cfg_index <= CFG_OFF_MIN;
        cfg_wdata <= minimum;
        board.set_register(CFG_OFF_MIN, minimum);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        writes_done += 3;
        @(negedge aclk);
    endtask

    // Offer one pixel and hold it until accepted; enter and leave on a falling edge.
    task send_pixel(input sample_t s);
        int g;
        g = gap_len(src_idle);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task run_pixels(input int count, input bit quiet);
        for (int i = 0; i < count; i++) send_pixel(pick_sample(quiet, i == 0));
        s_tvalid <= 1'b0;
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero threshold: every smoothed pixel is bright, raw zero ends are not.
        write_settings(14'd0, 14'd0, 14'd128);
        foreach (OPENING_PIXELS[i]) send_pixel(OPENING_PIXELS[i]);
        s_tvalid <= 1'b0;

        // Rest of line 0: widest span with the sender never idling (the
        // receiver hold-off lands here), then dark above white with an odd
        // span. Minimum of 128 leaves the line off track.
        write_settings(14'd16383, 14'd0, 14'd128);
        src_idle = 1'b0;
        run_pixels(52, 1'b0);
        src_idle = 1'b1;
        write_settings(14'd5, 14'd9000, 14'd128);
        run_pixels(52, 1'b0);

        // Line 1: only pixel 0 is bright, so the left edge moves to 0 and the
        // right edge carries over; a minimum of 2 leaves it off track.
        write_settings(14'd16383, 14'd0, 14'd2);
        run_pixels(LINE_LEN, 1'b1);

        // Opening of line 2: both levels at full scale, nothing can be bright,
        // minimum 0. No idling on either side.
        src_idle = 1'b0;
        snk_idle = 1'b0;
        write_settings(14'd16383, 14'd16383, 14'd0);
        run_pixels(TAIL_PIXELS, 1'b0);

        settle();
        $display("Checked %0d results from %0d pixels, %0d bright, %0d line summaries.",
                 board.checked, board.pixels_seen, board.bright_seen, board.lines_seen);
        $display("Made %0d register writes: level extremes, dark above white, minimum 0 to 128.",
                 writes_done);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/lstd_pkg.sv
hdl/lstd_window.sv
hdl/lstd_classify.sv
hdl/lstd_out_queue.sv
hdl/line_scan_track_detect_unit.sv
bench/testbench.sv
